// ===== rtl/core/telemetry_response_framer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry response framer
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_RESPONSE_FRAMER_DEFINES_SVH
`define TELEMETRY_RESPONSE_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TRF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("telemetry_response_framer: same-cycle check failed");
// Next-cycle implication.
`define TRF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("telemetry_response_framer: next-cycle check failed");
`else
`define TRF_ASSERT_IMP(label, ante, cons)
`define TRF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/trf_pkg.sv =====
// ----------------------------------------------------------------------------
// trf_pkg
// Shared constants and types of the telemetry response framer.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int FRAME_IW    = $clog2(FRAME_BYTES);
	localparam int SUM_W       = 11;

	localparam logic [7:0] FRAME_HEADER = 8'h10;
	localparam logic [7:0] FRAME_MARK   = 8'h7E;
	localparam logic [7:0] ESC_MARK     = 8'h7D;
	localparam logic [7:0] ESC_XOR      = 8'h20;
	localparam logic [7:0] CKS_BASE     = 8'hFF;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef logic [7:0] byte_t;

	// One reply frame with a flag per byte that marks bytes needing an escape.
	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] bytes;
		logic [FRAME_BYTES-1:0]      esc;
	} frame_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [FIFO_CW-1:0] cnt;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/trf_front.sv =====
// ----------------------------------------------------------------------------
// trf_front
// Packs an incoming transaction into a reply frame, adds the checksum and
// marks every byte that must be escaped.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_front (
	input  wire logic [15:0]     data_id,
	input  wire logic [31:0]     value,
	output trf_pkg::frame_t      frame
);

	logic [trf_pkg::SUM_W-1:0] sum;
	logic [trf_pkg::SUM_W-1:0] folded;
	trf_pkg::byte_t            cks;

	always_comb begin
		sum = trf_pkg::SUM_W'(trf_pkg::FRAME_HEADER)
			+ trf_pkg::SUM_W'(data_id[7:0]) + trf_pkg::SUM_W'(data_id[15:8])
			+ trf_pkg::SUM_W'(value[7:0])   + trf_pkg::SUM_W'(value[15:8])
			+ trf_pkg::SUM_W'(value[23:16]) + trf_pkg::SUM_W'(value[31:24]);
		// The sum stays below 2048, so one fold of the high part is exact.
		folded = sum + (sum >> 8);
		cks    = 8'(trf_pkg::SUM_W'(trf_pkg::CKS_BASE) - folded);
	end

	always_comb begin
		frame.bytes[0] = trf_pkg::FRAME_HEADER;
		frame.bytes[1] = data_id[7:0];
		frame.bytes[2] = data_id[15:8];
		frame.bytes[3] = value[7:0];
		frame.bytes[4] = value[15:8];
		frame.bytes[5] = value[23:16];
		frame.bytes[6] = value[31:24];
		frame.bytes[7] = cks;
		for (int i = 0; i < trf_pkg::FRAME_BYTES; i++) begin
			frame.esc[i] = (frame.bytes[i] == trf_pkg::FRAME_MARK)
				|| (frame.bytes[i] == trf_pkg::ESC_MARK);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/trf_fifo.sv =====
// ----------------------------------------------------------------------------
// trf_fifo
// Short frame queue that decouples the packing front from the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire trf_pkg::frame_t  wr_data,
	input  wire logic             rd_en,
	output trf_pkg::frame_t       rd_data,
	output trf_pkg::fifo_stat_t   stat
);

	trf_pkg::frame_t                  mem_q [trf_pkg::FIFO_DEPTH];
	logic [trf_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [trf_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [trf_pkg::FIFO_CW-1:0]      cnt_q;

	localparam logic [trf_pkg::FIFO_AW-1:0] LAST_PTR = trf_pkg::FIFO_AW'(trf_pkg::FIFO_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == trf_pkg::FIFO_CW'(trf_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.cnt   = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/trf_back.sv =====
// ----------------------------------------------------------------------------
// trf_back
// Walks a queued frame byte by byte, inserts escape pairs and holds each
// output byte in a register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire trf_pkg::frame_t fr_data,
	input  wire logic        fr_avail,
	output logic             fr_take,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             empty,
	input  wire logic        pop
);

	trf_pkg::frame_t              fr_q;
	logic                         busy_q;
	logic                         esc_q;
	logic [trf_pkg::FRAME_IW-1:0] idx_q;
	logic                         out_valid_q;
	trf_pkg::byte_t               out_byte_q;
	logic                         last_q;

	logic           adv;
	logic           step;
	logic           cur_esc;
	logic           at_end;
	logic           byte_done;
	trf_pkg::byte_t cur;

	assign adv       = !out_valid_q || pop;
	assign fr_take   = !busy_q && fr_avail;
	assign step      = busy_q && adv;
	assign cur       = fr_q.bytes[idx_q];
	assign cur_esc   = fr_q.esc[idx_q];
	assign at_end    = (idx_q == trf_pkg::FRAME_IW'(trf_pkg::FRAME_BYTES - 1));
	// A byte is finished once it is sent plainly or its escape pair completes.
	assign byte_done = esc_q || !cur_esc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			esc_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fr_take) begin
				busy_q <= 1'b1;
				esc_q  <= 1'b0;
				idx_q  <= '0;
			end else if (step) begin
				if (byte_done) begin
					esc_q <= 1'b0;
					idx_q <= idx_q + 1'b1;
					if (at_end) begin
						busy_q <= 1'b0;
					end
				end else begin
					esc_q <= 1'b1;
				end
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fr_take) begin
			fr_q <= fr_data;
		end
		if (step) begin
			if (esc_q) begin
				out_byte_q <= cur ^ trf_pkg::ESC_XOR;
			end else if (cur_esc) begin
				out_byte_q <= trf_pkg::ESC_MARK;
			end else begin
				out_byte_q <= cur;
			end
			last_q <= at_end && byte_done;
		end
	end

	assign out_byte = out_byte_q;
	assign last     = last_q;
	assign empty    = !out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/telemetry_response_framer.sv =====
// ----------------------------------------------------------------------------
// telemetry_response_framer
// Builds a checksummed sensor reply frame from each transaction and emits it
// byte-stuffed, one byte per output transaction.
// ----------------------------------------------------------------------------
// Usage. The input side behaves as a queue: drive data_id and value, raise
// push, and the transaction is taken at a rising edge where full is low.
// The output side also behaves as a queue: while empty is low the oldest
// byte sits on out_byte with last, and pop at a rising edge takes it.
// Each input transaction yields 8 to 14 output bytes: the eight frame bytes,
// with every 0x7E or 0x7D replaced by an escape pair. last is high only on
// the final byte, which is the second byte of a pair when the checksum is
// escaped.
// Latency: when the emitter is idle, the first byte of a frame passes through the
// frame queue, the emitter's frame register and the output register.
// Throughput: while pop is held high the emitter delivers one byte per cycle,
// and it loads each frame from the queue before its first byte. A two-entry
// frame queue lets the input side take further transactions meanwhile; full
// rises only once both entries are waiting.
// Stalls: when pop is held low the output byte holds, the emitter waits, and
// the queue fills, after which full holds the sender off. No byte is lost.
// Reset: arst_n clears the queue, the emitter and the output valid flag; the
// block is ready for a transaction as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telemetry_response_framer_defines.svh"

module telemetry_response_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] data_id,
	input  wire logic [31:0] value,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last
);

	trf_pkg::frame_t     frame_in;
	trf_pkg::frame_t     frame_out;
	trf_pkg::fifo_stat_t fifo_stat;
	logic                fifo_wr;
	logic                fifo_rd;

	// Front: pack the transaction and compute the checksum and escape flags.
	trf_front u_front (
		.data_id (data_id),
		.value   (value),
		.frame   (frame_in)
	);

	assign full    = fifo_stat.full;
	assign fifo_wr = push && !fifo_stat.full;

	// Frame queue between the two halves.
	trf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fifo_wr),
		.wr_data (frame_in),
		.rd_en   (fifo_rd),
		.rd_data (frame_out),
		.stat    (fifo_stat)
	);

	// Back: emit the stuffed bytes through the output register.
	trf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fr_data  (frame_out),
		.fr_avail (!fifo_stat.empty),
		.fr_take  (fifo_rd),
		.out_byte (out_byte),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

	// A frame never ends on an escape mark.
	`TRF_ASSERT_IMP(a_last_not_escape, (!empty && last), (out_byte != trf_pkg::ESC_MARK))
	// The byte after an escape mark is produced without a gap.
	`TRF_ASSERT_NXT(a_escape_pair_joined, (!empty && (out_byte == trf_pkg::ESC_MARK)), (!empty))
	// A frame taken in is held in the queue on the following cycle.
	`TRF_ASSERT_NXT(a_push_lands, (push && !full), (fifo_stat.cnt != '0))

endmodule

`default_nettype wire
